[rtl/mma_pkg.sv]
// Shared constants and payload types for the multichannel moving average.
`timescale 1ns / 1ps
`default_nettype none

package mma_pkg;

	localparam int unsigned WINDOW_LEN_DEF    = 20;
	localparam int unsigned CHANNEL_COUNT_DEF = 2;
	localparam int unsigned SAMPLE_BITS_DEF   = 10;

	localparam int unsigned SLOT_W   = 1;
	localparam int unsigned SAMPLE_W = 10;
	localparam int unsigned AVG_W    = 10;

	// items in flight between acceptance and the result queue
	localparam int unsigned PIPE_DEPTH  = 2;
	localparam int unsigned QUEUE_DEPTH = 4;

	typedef logic [SLOT_W-1:0]   slot_t;
	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [AVG_W-1:0]    avg_t;

endpackage

`default_nettype wire

[rtl/mma_in_if.sv]
// Input channel: channel slot and converter sample per beat.
`timescale 1ns / 1ps
`default_nettype none

interface mma_in_if;
	import mma_pkg::*;

	logic    valid;
	logic    ready;
	slot_t   channel_slot;
	sample_t sample;

	modport source (output valid, output channel_slot, output sample, input ready);
	modport sink (input valid, input channel_slot, input sample, output ready);
endinterface

`default_nettype wire

[rtl/mma_out_if.sv]
// Output channel: one average per beat.
`timescale 1ns / 1ps
`default_nettype none

interface mma_out_if;
	import mma_pkg::*;

	logic valid;
	logic ready;
	avg_t average;

	modport source (output valid, output average, input ready);
	modport sink (input valid, input average, output ready);
endinterface

`default_nettype wire

[rtl/mma_ram.sv]
// Generic simple dual-port RAM, registered read, read-before-write.
`timescale 1ns / 1ps
`default_nettype none

module mma_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[rtl/mma_rmw.sv]
// Window store read-modify-write, shared position, per-channel sums and clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module mma_rmw #(
	parameter int unsigned WINDOW_LEN    = 20,
	parameter int unsigned CHANNEL_COUNT = 2,
	parameter int unsigned SAMPLE_BITS   = 10,
	parameter int unsigned SUM_W         = 15
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  mma_pkg::slot_t   slot,
	input  mma_pkg::sample_t sample,
	output logic             busy,
	output logic             sum_valid,
	output logic [SUM_W-1:0] sum
);
	import mma_pkg::*;

	localparam int unsigned DEPTH  = WINDOW_LEN * CHANNEL_COUNT;
	localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned POS_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam int unsigned CH_W   = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
	localparam int unsigned CMP_W  = 5;
	localparam logic [CMP_W-1:0] CH_COUNT = CMP_W'(CHANNEL_COUNT);
	localparam logic [CMP_W-1:0] LAST_CH  = CMP_W'(CHANNEL_COUNT - 1);

	logic [POS_W-1:0]       pos_q;
	logic                   clearing_q;
	logic [ADDR_W-1:0]      clr_addr_q;
	logic                   in_range;
	logic [ADDR_W-1:0]      rd_addr;
	logic [SAMPLE_BITS-1:0] smp;

	logic                   s1_valid_q;
	logic                   s1_in_range_q;
	logic [CH_W-1:0]        s1_ch_q;
	logic [ADDR_W-1:0]      s1_addr_q;
	logic [SAMPLE_BITS-1:0] s1_sample_q;

	logic                   lastwr_valid_q;
	logic [ADDR_W-1:0]      lastwr_addr_q;
	logic [SAMPLE_BITS-1:0] lastwr_data_q;

	logic [SUM_W-1:0]       sums_q [CHANNEL_COUNT];
	logic [SAMPLE_BITS-1:0] ram_rdata;
	logic [SAMPLE_BITS-1:0] old_sample;
	logic [SUM_W-1:0]       sum_next;
	logic                   s1_write;
	logic                   ram_we;
	logic [ADDR_W-1:0]      ram_waddr;
	logic [SAMPLE_BITS-1:0] ram_wdata;

	assign in_range = CMP_W'(slot) < CH_COUNT;
	assign rd_addr  = ADDR_W'(pos_q) + ADDR_W'(slot * WINDOW_LEN);
	assign smp      = SAMPLE_BITS'(sample);
	assign busy     = clearing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept && in_range && CMP_W'(slot) == LAST_CH) begin
			if (pos_q == POS_W'(WINDOW_LEN - 1)) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_in_range_q <= in_range;
			s1_ch_q       <= CH_W'(slot);
			s1_addr_q     <= rd_addr;
			s1_sample_q   <= smp;
		end
	end

	// the RAM returns old data when read and written at once: forward the last write
	assign old_sample = (lastwr_valid_q && lastwr_addr_q == s1_addr_q) ? lastwr_data_q
		: ram_rdata;
	assign sum_next   = sums_q[s1_ch_q] - SUM_W'(old_sample) + SUM_W'(s1_sample_q);
	assign s1_write   = s1_valid_q && s1_in_range_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lastwr_valid_q <= 1'b0;
		end else begin
			lastwr_valid_q <= s1_write;
		end
	end

	always_ff @(posedge clk) begin
		lastwr_addr_q <= s1_addr_q;
		lastwr_data_q <= s1_sample_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNEL_COUNT; i++) begin
				sums_q[i] <= '0;
			end
		end else if (s1_write) begin
			sums_q[s1_ch_q] <= sum_next;
		end
	end

	assign ram_we    = clearing_q || s1_write;
	assign ram_waddr = clearing_q ? clr_addr_q : s1_addr_q;
	assign ram_wdata = clearing_q ? '0 : s1_sample_q;

	mma_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept && in_range),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	assign sum_valid = s1_valid_q;
	assign sum       = s1_in_range_q ? sum_next : '0;

endmodule

`default_nettype wire

[rtl/mma_div.sv]
// Division of the window sum by the window length through a reciprocal multiply.
`timescale 1ns / 1ps
`default_nettype none

module mma_div #(
	parameter int unsigned WINDOW_LEN = 20,
	parameter int unsigned SUM_W      = 15
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sum_valid,
	input  logic [SUM_W-1:0] sum,
	output logic             push,
	output mma_pkg::avg_t    push_avg
);
	import mma_pkg::*;

	// exact for every sum below 2**SUM_W with the rounded-up reciprocal
	localparam int unsigned SHIFT   = SUM_W + $clog2(WINDOW_LEN);
	localparam int unsigned RECIP_W = SUM_W + 1;
	localparam int unsigned PROD_W  = SUM_W + RECIP_W;
	localparam logic [63:0] RECIP_FULL =
		((64'd1 << SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

	logic             valid_s2;
	logic [SUM_W-1:0] sum_s2;
	logic [PROD_W-1:0] prod;
	logic [PROD_W-1:0] quot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= sum_valid;
		end
	end

	always_ff @(posedge clk) begin
		sum_s2 <= sum;
	end

	assign prod     = PROD_W'(sum_s2) * PROD_W'(RECIP);
	assign quot     = prod >> SHIFT;
	assign push     = valid_s2;
	assign push_avg = AVG_W'(quot);

endmodule

`default_nettype wire

[rtl/mma_fifo.sv]
// Result queue that decouples the pipeline from the output handshake.
`timescale 1ns / 1ps
`default_nettype none

module mma_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mma_pkg::avg_t push_avg,
	output logic          room,
	mma_out_if.source     averages
);
	import mma_pkg::*;

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	avg_t             entries_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             pop;

	assign pop = averages.valid && averages.ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_avg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	// space for one more beat on top of everything already in flight
	assign room             = count_q <= CNT_W'(QUEUE_DEPTH - PIPE_DEPTH - 1);
	assign averages.valid   = count_q != '0;
	assign averages.average = entries_q[rd_ptr_q];

endmodule

`default_nettype wire

[rtl/multichannel_moving_average.sv]
// Multichannel boxcar moving average: top level.
// Each accepted beat is registered in the read-modify-write stage, the divider and the
// result queue. Throughput: one beat per cycle while ready is high; the window store
// is read on acceptance and written back in the following cycle, with forwarding
// between neighbouring beats. Reset: sums and position clear at once; the window
// store's CHANNEL_COUNT * WINDOW_LEN entries (40 by default) then clear, ready held low.
`timescale 1ns / 1ps
`default_nettype none

module multichannel_moving_average #(
	parameter int unsigned WINDOW_LEN    = mma_pkg::WINDOW_LEN_DEF,
	parameter int unsigned CHANNEL_COUNT = mma_pkg::CHANNEL_COUNT_DEF,
	parameter int unsigned SAMPLE_BITS   = mma_pkg::SAMPLE_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	mma_in_if.sink    samples,
	mma_out_if.source averages
);
	import mma_pkg::*;

	localparam int unsigned SUM_W = SAMPLE_BITS + $clog2(WINDOW_LEN);

	logic             busy;
	logic             room;
	logic             accept;
	logic             sum_valid;
	logic [SUM_W-1:0] sum;
	logic             push;
	avg_t             push_avg;

	assign samples.ready = !busy && room;
	assign accept        = samples.valid && samples.ready;

	mma_rmw #(
		.WINDOW_LEN    (WINDOW_LEN),
		.CHANNEL_COUNT (CHANNEL_COUNT),
		.SAMPLE_BITS   (SAMPLE_BITS),
		.SUM_W         (SUM_W)
	) u_rmw (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.slot      (samples.channel_slot),
		.sample    (samples.sample),
		.busy      (busy),
		.sum_valid (sum_valid),
		.sum       (sum)
	);

	mma_div #(
		.WINDOW_LEN (WINDOW_LEN),
		.SUM_W      (SUM_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.sum_valid (sum_valid),
		.sum       (sum),
		.push      (push),
		.push_avg  (push_avg)
	);

	mma_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_avg (push_avg),
		.room     (room),
		.averages (averages)
	);

endmodule

`default_nettype wire
